/* sv/bsv_pkg.sv */
// Shared types and constants for the blit surface validator.
package bsv_pkg;

  typedef enum logic [1:0] {
    VerdictReject   = 2'd0,
    VerdictSoftware = 2'd1,
    VerdictHardware = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    FmtIndexed8    = 2'd0,
    FmtRgb16       = 2'd1,
    FmtRgb32       = 2'd2,
    FmtUnsupported = 2'd3
  } pixel_format_e;

  localparam logic [2:0] CfgCpuMemoryBase   = 3'd0;
  localparam logic [2:0] CfgApertureSize    = 3'd1;
  localparam logic [2:0] CfgBoardMemorySize = 3'd2;
  localparam logic [2:0] CfgInstalledVram   = 3'd3;
  localparam logic [2:0] CfgFbGpuBase       = 3'd4;

  localparam logic [14:0] MaxPitch = 15'd16320;
  localparam logic [16:0] MaxCoord = 17'd8191;

endpackage

/* sv/blit_surface_validator.sv */
// Blit surface validator: classifies blit rectangle requests, four-stage pipeline.
// Throughput: one request per cycle while in_stall_o is low;
// the stage valid chain collapses bubbles under stall.
// Stages: checks and offset, multipliers and GPU sum, end sums and row bias, verdict.
// Reset clears stage valid bits and all configuration registers to zero.
module blit_surface_validator
  import bsv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [31:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [31:0] surface_address_i,
  input  logic signed [15:0] row_bytes_i,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic signed [15:0] rect_width_i,
  input  logic signed [15:0] rect_height_i,
  input  logic        [1:0]  pixel_format_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [1:0]  verdict_o,
  output logic        [31:0] pitch_offset_o,
  output logic        [31:0] start_offset_o,
  output logic        [31:0] end_offset_o,
  output logic        [9:0]  x_bias_o,
  output logic        [3:0]  y_bias_o
);

  typedef struct packed {
    logic        sw_surface;
    logic        rej_empty;
    logic        sw_origin;
    logic        sw_aperture;
    logic        sw_pitch;
  } early_t;

  typedef struct packed {
    early_t      fl;
    logic [1:0]  fmt;
    logic [14:0] pitch;
    logic [14:0] x;
    logic [14:0] y;
    logic [15:0] xw;
    logic [15:0] xw1;
    logic [15:0] yh1;
    logic [31:0] off;
    logic [31:0] lim01;
  } s1_t;

  typedef struct packed {
    early_t      fl;
    logic        rej_gpu;
    logic [1:0]  fmt;
    logic [14:0] pitch;
    logic [15:0] xw1;
    logic [15:0] yh1;
    logic [31:0] off;
    logic [31:0] limit;
    logic [31:0] gpu;
    logic [29:0] p_start;
    logic [30:0] p_end;
    logic [17:0] line_end;
    logic [16:0] xs;
  } s2_t;

  typedef struct packed {
    early_t      fl;
    logic        rej_gpu;
    logic        rej_mem;
    logic        rej_line;
    logic [1:0]  fmt;
    logic [7:0]  k;
    logic [15:0] xw1;
    logic [15:0] yh1;
    logic [31:0] limit;
    logic [21:0] gpu_hi;
    logic [3:0]  q;
    logic [5:0]  r;
    logic [3:0]  yb;
    logic [33:0] rect_end;
    logic [32:0] rect_start;
  } s3_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] pitch_offset;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [9:0]  x_bias;
    logic [3:0]  y_bias;
  } s4_t;

  logic [31:0] cpu_base_q, ap_size_q, board_size_q, vram_q, fb_base_q;
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        rdy1, rdy2, rdy3, rdy4;
  s1_t         s1_d, s1_q;
  s2_t         s2_d, s2_q;
  s3_t         s3_d, s3_q;
  s4_t         s4_d, s4_q;

  logic [32:0] ap_end;
  logic [11:0] yb_prod;
  logic [3:0]  yb_acc;
  logic [9:0]  rem2;
  logic [9:0]  xb;
  logic        sw_pix, sw_coord, rej_rect;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_base_q   <= '0;
      ap_size_q    <= '0;
      board_size_q <= '0;
      vram_q       <= '0;
      fb_base_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgCpuMemoryBase:   cpu_base_q   <= cfg_data_i;
        CfgApertureSize:    ap_size_q    <= cfg_data_i;
        CfgBoardMemorySize: board_size_q <= cfg_data_i;
        CfgInstalledVram:   vram_q       <= cfg_data_i;
        CfgFbGpuBase:       fb_base_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake
  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdy4 && v3_q)       s4_q <= s4_d;
  end

  // stage 1: early checks, aperture, offset
  always_comb begin
    ap_end                = {1'b0, cpu_base_q} + {1'b0, ap_size_q};
    s1_d.fl.sw_surface    = (pixel_format_i == FmtUnsupported) || (surface_address_i == '0) ||
                            row_bytes_i[15] || (row_bytes_i == '0);
    s1_d.fl.rej_empty     = rect_width_i[15] || (rect_width_i == '0) ||
                            rect_height_i[15] || (rect_height_i == '0);
    s1_d.fl.sw_origin     = rect_x_i[15] || rect_y_i[15];
    s1_d.fl.sw_aperture   = (surface_address_i < cpu_base_q) ||
                            ({1'b0, surface_address_i} >= ap_end);
    s1_d.fl.sw_pitch      = (row_bytes_i[5:0] != '0) || (row_bytes_i[14:0] > MaxPitch);
    s1_d.fmt              = pixel_format_i;
    s1_d.pitch            = row_bytes_i[14:0];
    s1_d.x                = rect_x_i[14:0];
    s1_d.y                = rect_y_i[14:0];
    s1_d.xw               = 16'(rect_x_i[14:0]) + 16'(rect_width_i[14:0]);
    s1_d.xw1              = 16'(rect_x_i[14:0]) + 16'(rect_width_i[14:0]) - 16'd1;
    s1_d.yh1              = 16'(rect_y_i[14:0]) + 16'(rect_height_i[14:0]) - 16'd1;
    s1_d.off              = surface_address_i - cpu_base_q;
    s1_d.lim01            = (vram_q < board_size_q) ? vram_q : board_size_q;
  end

  // stage 2: products, limit, GPU address
  logic [32:0] gpu_sum;
  always_comb begin
    gpu_sum         = {1'b0, fb_base_q} + {1'b0, s1_q.off};
    s2_d.fl         = s1_q.fl;
    s2_d.rej_gpu    = gpu_sum[32];
    s2_d.fmt        = s1_q.fmt;
    s2_d.pitch      = s1_q.pitch;
    s2_d.xw1        = s1_q.xw1;
    s2_d.yh1        = s1_q.yh1;
    s2_d.off        = s1_q.off;
    s2_d.limit      = (ap_size_q < s1_q.lim01) ? ap_size_q : s1_q.lim01;
    s2_d.gpu        = gpu_sum[31:0];
    s2_d.p_start    = 30'(s1_q.y) * 30'(s1_q.pitch);
    s2_d.p_end      = 31'(s1_q.yh1) * 31'(s1_q.pitch);
    s2_d.line_end   = 18'(s1_q.xw) << s1_q.fmt;
    s2_d.xs         = 17'(s1_q.x) << s1_q.fmt;
  end

  // stage 3: rectangle sums, row bias; pitch/64 times m against rem/64
  always_comb begin
    yb_acc = '0;
    for (int m = 1; m < 16; m++) begin
      if (12'(m) * 12'(s2_q.pitch[13:6]) <= 12'(s2_q.gpu[9:6])) yb_acc = yb_acc + 4'd1;
    end
    s3_d.fl         = s2_q.fl;
    s3_d.rej_gpu    = s2_q.rej_gpu;
    s3_d.rej_mem    = s2_q.off >= s2_q.limit;
    s3_d.rej_line   = 18'(s2_q.pitch) < s2_q.line_end;
    s3_d.fmt        = s2_q.fmt;
    s3_d.k          = s2_q.pitch[13:6];
    s3_d.xw1        = s2_q.xw1;
    s3_d.yh1        = s2_q.yh1;
    s3_d.limit      = s2_q.limit;
    s3_d.gpu_hi     = s2_q.gpu[31:10];
    s3_d.q          = s2_q.gpu[9:6];
    s3_d.r          = s2_q.gpu[5:0];
    s3_d.yb         = yb_acc;
    s3_d.rect_end   = 34'(s2_q.off) + 34'(s2_q.p_end) + 34'(s2_q.line_end);
    s3_d.rect_start = 33'(s2_q.off) + 33'(s2_q.p_start) + 33'(s2_q.xs);
  end

  // stage 4: column bias, coordinate limit, verdict
  always_comb begin
    yb_prod  = 12'(s3_q.yb) * 12'(s3_q.k);
    rem2     = {s3_q.q - yb_prod[3:0], s3_q.r};
    xb       = rem2 >> s3_q.fmt;
    sw_pix   = (s3_q.fmt == FmtRgb16) ? s3_q.r[0] :
               (s3_q.fmt == FmtRgb32) ? (s3_q.r[1:0] != '0) : 1'b0;
    sw_coord = (17'(xb) + 17'(s3_q.xw1) > MaxCoord) ||
               (17'(s3_q.yb) + 17'(s3_q.yh1) > MaxCoord);
    rej_rect = s3_q.rej_line || (s3_q.rect_end > 34'(s3_q.limit));

    if (s3_q.fl.sw_surface)       s4_d.verdict = VerdictSoftware;
    else if (s3_q.fl.rej_empty)   s4_d.verdict = VerdictReject;
    else if (s3_q.fl.sw_origin)   s4_d.verdict = VerdictSoftware;
    else if (s3_q.fl.sw_aperture) s4_d.verdict = VerdictSoftware;
    else if (s3_q.rej_mem)        s4_d.verdict = VerdictReject;
    else if (rej_rect)            s4_d.verdict = VerdictReject;
    else if (s3_q.fl.sw_pitch)    s4_d.verdict = VerdictSoftware;
    else if (s3_q.rej_gpu)        s4_d.verdict = VerdictReject;
    else if (sw_pix)              s4_d.verdict = VerdictSoftware;
    else if (sw_coord)            s4_d.verdict = VerdictSoftware;
    else                          s4_d.verdict = VerdictHardware;

    if (s4_d.verdict == VerdictHardware) begin
      s4_d.pitch_offset = {2'b00, s3_q.k, s3_q.gpu_hi};
      s4_d.start_offset = s3_q.rect_start[31:0];
      s4_d.end_offset   = s3_q.rect_end[31:0];
      s4_d.x_bias       = xb;
      s4_d.y_bias       = s3_q.yb;
    end else begin
      s4_d.pitch_offset = '0;
      s4_d.start_offset = '0;
      s4_d.end_offset   = '0;
      s4_d.x_bias       = '0;
      s4_d.y_bias       = '0;
    end
  end

  assign out_valid_o    = v4_q;
  assign verdict_o      = s4_q.verdict;
  assign pitch_offset_o = s4_q.pitch_offset;
  assign start_offset_o = s4_q.start_offset;
  assign end_offset_o   = s4_q.end_offset;
  assign x_bias_o       = s4_q.x_bias;
  assign y_bias_o       = s4_q.y_bias;

endmodule

/* tb/blit_surface_validator_tb.sv */
// Testbench for the blit surface validator: random and directed requests against a predictor.
`timescale 1ns / 100ps

module blit_surface_validator_tb
  import bsv_pkg::*;
();

  localparam int unsigned PipeLatency = 4;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned LongHold    = 300;

  typedef struct {
    logic        [31:0] surface_address;
    logic signed [15:0] row_bytes;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic        [1:0]  pixel_format;
  } blit_request_t;

  typedef struct {
    verdict_e    verdict;
    logic [31:0] pitch_offset;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [9:0]  x_bias;
    logic [3:0]  y_bias;
  } blit_result_t;

  typedef struct {
    logic [31:0] cpu_base;
    logic [31:0] aper_size;
    logic [31:0] board_size;
    logic [31:0] vram_size;
    logic [31:0] gpu_base;
  } reg_set_t;

  class verdict_scoreboard;
    logic [31:0] cpu_base   = '0;
    logic [31:0] aper_size  = '0;
    logic [31:0] board_size = '0;
    logic [31:0] vram_size  = '0;
    logic [31:0] gpu_base   = '0;
    blit_result_t expected_verdicts[$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned n_hw = 0;
    int unsigned n_sw = 0;
    int unsigned n_rej = 0;

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CfgCpuMemoryBase:   cpu_base = val;
        CfgApertureSize:    aper_size = val;
        CfgBoardMemorySize: board_size = val;
        CfgInstalledVram:   vram_size = val;
        CfgFbGpuBase:       gpu_base = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] memory_limit();
      logic [63:0] lim;
      lim = {32'd0, board_size};
      if ({32'd0, vram_size} < lim) lim = {32'd0, vram_size};
      if ({32'd0, aper_size} < lim) lim = {32'd0, aper_size};
      return lim;
    endfunction

    function blit_result_t predict_verdict(blit_request_t r);
      blit_result_t res;
      logic [63:0] bpp, lim, off, pitch, line_end, rect_end, rect_start;
      logic [63:0] gpu, aligned, rem, yb, xb, px, py, pw, ph;
      res.verdict = VerdictSoftware;
      res.pitch_offset = '0;
      res.start_offset = '0;
      res.end_offset = '0;
      res.x_bias = '0;
      res.y_bias = '0;
      case (r.pixel_format)
        FmtIndexed8: bpp = 64'd1;
        FmtRgb16:    bpp = 64'd2;
        FmtRgb32:    bpp = 64'd4;
        default:     bpp = 64'd0;
      endcase
      if (bpp == 64'd0 || r.surface_address == 32'd0 || r.row_bytes <= 0) return res;
      if (r.rect_width <= 0 || r.rect_height <= 0) begin
        res.verdict = VerdictReject;
        return res;
      end
      if (r.rect_x < 0 || r.rect_y < 0) return res;
      lim = memory_limit();
      if (r.surface_address < cpu_base ||
          {32'd0, r.surface_address} >= {32'd0, cpu_base} + {32'd0, aper_size}) return res;
      off = {32'd0, r.surface_address - cpu_base};
      if (off >= lim) begin
        res.verdict = VerdictReject;
        return res;
      end
      pitch = {48'd0, r.row_bytes};
      px = {48'd0, r.rect_x};
      py = {48'd0, r.rect_y};
      pw = {48'd0, r.rect_width};
      ph = {48'd0, r.rect_height};
      line_end = (px + pw) * bpp;
      rect_end = off + (py + ph - 64'd1) * pitch + line_end;
      rect_start = off + py * pitch + px * bpp;
      if (line_end > pitch || rect_end > lim) begin
        res.verdict = VerdictReject;
        return res;
      end
      if (pitch[5:0] != 6'd0 || pitch > 64'(MaxPitch)) return res;
      if ({32'd0, gpu_base} > 64'hFFFF_FFFF - off) begin
        res.verdict = VerdictReject;
        return res;
      end
      gpu = {32'd0, gpu_base} + off;
      aligned = gpu & 64'hFFFF_FC00;
      if (aligned > 64'hFFFF_FC00) return res;
      rem = gpu - aligned;
      yb = rem / pitch;
      rem = rem - yb * pitch;
      if (rem % bpp != 64'd0) return res;
      xb = rem / bpp;
      if (xb + px + pw - 64'd1 > 64'(MaxCoord) || yb + py + ph - 64'd1 > 64'(MaxCoord))
        return res;
      res.verdict = VerdictHardware;
      res.pitch_offset = 32'(((pitch >> 6) << 22) | (aligned >> 10));
      res.start_offset = rect_start[31:0];
      res.end_offset = rect_end[31:0];
      res.x_bias = xb[9:0];
      res.y_bias = yb[3:0];
      return res;
    endfunction

    function void note_request(blit_request_t r);
      blit_result_t want;
      want = predict_verdict(r);
      case (want.verdict)
        VerdictHardware: n_hw++;
        VerdictSoftware: n_sw++;
        default:         n_rej++;
      endcase
      expected_verdicts.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(blit_result_t got);
      blit_result_t want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual verdict %0d",
                 $time, got.verdict);
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("verdict", 32'(want.verdict), 32'(got.verdict));
      compare_field("pitch_offset", want.pitch_offset, got.pitch_offset);
      compare_field("start_offset", want.start_offset, got.start_offset);
      compare_field("end_offset", want.end_offset, got.end_offset);
      compare_field("x_bias", 32'(want.x_bias), 32'(got.x_bias));
      compare_field("y_bias", 32'(want.y_bias), 32'(got.y_bias));
      checked++;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic        [2:0]  cfg_index_i = '0;
  logic        [31:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic        [31:0] surface_address_i = '0;
  logic signed [15:0] row_bytes_i = '0;
  logic signed [15:0] rect_x_i = '0;
  logic signed [15:0] rect_y_i = '0;
  logic signed [15:0] rect_width_i = '0;
  logic signed [15:0] rect_height_i = '0;
  logic        [1:0]  pixel_format_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic        [1:0]  verdict_o;
  logic        [31:0] pitch_offset_o;
  logic        [31:0] start_offset_o;
  logic        [31:0] end_offset_o;
  logic        [9:0]  x_bias_o;
  logic        [3:0]  y_bias_o;

  verdict_scoreboard sb = new();

  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  int unsigned hold_request = 0;
  int unsigned holds_done = 0;
  int unsigned settings_loaded = 0;
  int unsigned idle_cycles = 0;

  blit_surface_validator dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // no word moved on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic load_registers(reg_set_t s);
    logic [2:0]  idx [5];
    logic [31:0] val [5];
    idx = '{CfgCpuMemoryBase, CfgApertureSize, CfgBoardMemorySize, CfgInstalledVram,
            CfgFbGpuBase};
    val = '{s.cpu_base, s.aper_size, s.board_size, s.vram_size, s.gpu_base};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_request(blit_request_t r);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    surface_address_i <= r.surface_address;
    row_bytes_i       <= r.row_bytes;
    rect_x_i          <= r.rect_x;
    rect_y_i          <= r.rect_y;
    rect_width_i      <= r.rect_width;
    rect_height_i     <= r.rect_height;
    pixel_format_i    <= r.pixel_format;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  function automatic blit_request_t mk_req(logic [31:0] addr, int rb, int x, int y, int w,
                                           int h, pixel_format_e fmt);
    blit_request_t r;
    r.surface_address = addr;
    r.row_bytes = 16'(rb);
    r.rect_x = 16'(x);
    r.rect_y = 16'(y);
    r.rect_width = 16'(w);
    r.rect_height = 16'(h);
    r.pixel_format = fmt;
    return r;
  endfunction

  // mostly well-formed requests aimed inside the current aperture, some corrupted, some noise
  function automatic blit_request_t random_request();
    blit_request_t r;
    logic [63:0] lim, off;
    int unsigned kind, bpp, pitch, maxpx, cap, x, w, y, h;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      r.surface_address = $urandom;
      r.row_bytes = 16'($urandom);
      r.rect_x = 16'($urandom);
      r.rect_y = 16'($urandom);
      r.rect_width = 16'($urandom);
      r.rect_height = 16'($urandom);
      r.pixel_format = 2'($urandom);
      return r;
    end
    r.pixel_format = 2'($urandom_range(0, 2));
    bpp = 1 << r.pixel_format;
    pitch = ($urandom_range(0, 9) < 8) ? 64 * $urandom_range(1, 255) : $urandom_range(1, 16448);
    maxpx = pitch / bpp;
    cap = ($urandom_range(0, 9) < 8) ? 64 : 8400;
    if (maxpx == 0) begin
      x = 0;
      w = 1;
    end else begin
      x = $urandom_range(0, (maxpx - 1 < cap) ? maxpx - 1 : cap);
      w = $urandom_range(1, (maxpx - x < cap) ? maxpx - x : cap);
    end
    if (cap == 64) begin
      y = $urandom_range(0, 40);
      h = $urandom_range(1, 40);
    end else begin
      y = $urandom_range(0, 8400);
      h = $urandom_range(1, 400);
    end
    lim = sb.memory_limit();
    if (lim == 64'd0) begin
      off = 64'($urandom_range(0, 4095));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: off = 64'($urandom_range(0, (lim > 64'h1_0000) ? 32'hFFFF : 32'(lim - 1)));
        5, 6, 7:       off = 64'($urandom_range(0, 32'(lim - 1)));
        default: begin
          if (lim > 64'd4096) off = lim - 64'($urandom_range(0, 4096));
          else off = 64'($urandom_range(0, 32'(lim - 1)));
        end
      endcase
    end
    if ($urandom_range(0, 3) != 0) off = off & ~64'(bpp - 1);
    r.surface_address = sb.cpu_base + off[31:0];
    r.row_bytes = 16'(pitch);
    r.rect_x = 16'(x);
    r.rect_y = 16'(y);
    r.rect_width = 16'(w);
    r.rect_height = 16'(h);
    if (kind < 35) begin
      case ($urandom_range(0, 6))
        0: r.surface_address = '0;
        1: r.pixel_format = FmtUnsupported;
        2: r.row_bytes = 16'(0 - $urandom_range(0, 32768));
        3: r.rect_width = 16'(0 - $urandom_range(0, 32768));
        4: r.rect_height = 16'(0 - $urandom_range(0, 32768));
        5: r.rect_x = 16'(0 - $urandom_range(1, 32768));
        default: r.rect_y = 16'(0 - $urandom_range(1, 32768));
      endcase
    end
    return r;
  endfunction

  task automatic run_random(int unsigned count, bit flood);
    for (int unsigned n = 0; n < count; n++) begin
      if (flood) send_burst = 1'b1;
      else if (n % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_request(random_request());
    end
  endtask

  task automatic run_directed_typical();
    logic [31:0] b;
    b = sb.cpu_base;
    send_burst = 1'b0;
    send_request(mk_req(b, 64, 0, 0, 1, 1, FmtUnsupported));        // unsupported format
    send_request(mk_req(32'd0, 64, 0, 0, 1, 1, FmtIndexed8));       // null address
    send_request(mk_req(b, 0, 0, 0, 1, 1, FmtIndexed8));            // zero pitch
    send_request(mk_req(b, -32768, 0, 0, 1, 1, FmtIndexed8));
    send_request(mk_req(b, 64, 0, 0, 0, 1, FmtIndexed8));           // empty rectangle
    send_request(mk_req(b, 64, 0, 0, 1, -32768, FmtIndexed8));
    send_request(mk_req(b, 64, -1, 0, 1, 1, FmtIndexed8));          // negative origin
    send_request(mk_req(b, 64, 0, -32768, 1, 1, FmtIndexed8));
    send_request(mk_req(b - 32'd1, 64, 0, 0, 1, 1, FmtIndexed8));   // below aperture
    send_request(mk_req(b + sb.aper_size, 64, 0, 0, 1, 1, FmtIndexed8));  // past aperture
    send_request(mk_req(b + 32'(sb.memory_limit()), 64, 0, 0, 1, 1, FmtIndexed8));
    send_request(mk_req(b, 64, 60, 0, 5, 1, FmtIndexed8));          // row overrun
    send_request(mk_req(b + 32'(sb.memory_limit()) - 32'h40, 64, 0, 0, 1, 2, FmtIndexed8));
    send_request(mk_req(b, 100, 0, 0, 1, 1, FmtIndexed8));          // pitch not 64-aligned
    send_request(mk_req(b, 16384, 0, 0, 1, 1, FmtIndexed8));        // pitch too large
    send_request(mk_req(b, 16320, 0, 0, 4080, 1, FmtRgb32));
    send_request(mk_req(b + 32'h201, 64, 0, 0, 1, 1, FmtRgb16));    // half-pixel remainder
    send_request(mk_req(b, 16320, 8000, 0, 200, 1, FmtIndexed8));   // column limit
    send_request(mk_req(b, 64, 0, 8000, 1, 200, FmtIndexed8));      // row limit
    send_request(mk_req(b, 16320, 0, 0, 8192, 1, FmtIndexed8));
    send_request(mk_req(b, 64, 0, 8191, 1, 1, FmtIndexed8));
    send_request(mk_req(32'hFFFF_FFFF, 32767, 32767, 32767, 32767, 32767, FmtRgb32));
    send_request(mk_req(b + 32'h3C0, 256, 2, 3, 10, 5, FmtRgb32));  // both biases
  endtask

  task automatic run_directed_wrap();
    logic [31:0] b;
    b = sb.cpu_base;
    send_request(mk_req(b + 32'h0010_0000, 64, 0, 0, 1, 1, FmtIndexed8));  // GPU sum wraps
    send_request(mk_req(b + 32'h000F_FC00, 64, 0, 0, 1, 1, FmtIndexed8));  // top aligned page
  endtask

  // receiver: random stalls, bursts, and one long hold on request
  initial begin
    blit_result_t got;
    int unsigned gap;
    int unsigned n;
    n = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (n % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 15);
      if (hold_request != 0) begin
        gap = hold_request;
        hold_request = 0;
        holds_done++;
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.verdict = verdict_e'(verdict_o);
      got.pitch_offset = pitch_offset_o;
      got.start_offset = start_offset_o;
      got.end_offset = end_offset_o;
      got.x_bias = x_bias_o;
      got.y_bias = y_bias_o;
      sb.check_result(got);
      n++;
    end
  end

  initial begin
    reg_set_t settings [8];
    settings[0] = '{32'hE000_0000, 32'h0800_0000, 32'h0400_0000, 32'h0200_0000, 32'h1000_0000};
    settings[1] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFF0_0000};
    settings[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_03FF};
    settings[3] = '{32'h0000_0001, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0000_0000};
    settings[4] = '{32'h8000_0000, 32'h1000_0000, 32'h0080_0000, 32'h0400_0000, 32'h2000_0140};
    settings[5] = '{$urandom, $urandom, $urandom, $urandom, $urandom};
    settings[6] = '{$urandom_range(0, 32'h7FFF_FFFF), $urandom_range(1, 32'h0100_0000),
                    $urandom_range(1, 32'h0100_0000), $urandom_range(1, 32'h0100_0000),
                    $urandom};
    settings[7] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at reset values
    run_random(50, 1'b0);
    for (int p = 0; p < 8; p++) begin
      quiesce();
      load_registers(settings[p]);
      if (p == 0) begin
        run_directed_typical();
        hold_request = LongHold;
        run_random(40, 1'b1);
      end
      if (p == 1) run_directed_wrap();
      run_random(120, 1'b0);
    end
    quiesce();

    $display("Covered %0d requests under %0d register settings with %0d long output holds.",
             sb.checked, settings_loaded, holds_done);
    $display("Predicted verdicts: %0d hardware, %0d software, %0d reject.",
             sb.n_hw, sb.n_sw, sb.n_rej);
    if (sb.errors == 0 && sb.expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
